FILE: src/extended_gcd_mod_inverse_macros.svh
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse_macros
// assertion helpers for the extended gcd block
// ----------------------------------------------------------------------------
`ifndef EXTENDED_GCD_MOD_INVERSE_MACROS_SVH
`define EXTENDED_GCD_MOD_INVERSE_MACROS_SVH
`define EGM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/egm_pkg.sv
// ----------------------------------------------------------------------------
// egm_pkg
// shared types for the extended gcd block
// ----------------------------------------------------------------------------
package egm_pkg;
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
        logic mul_step;
        logic finish;
    } t_egm_cmd;

    typedef struct packed {
        logic b_zero;
        logic div_last;
        logic mul_last;
    } t_egm_sts;
endpackage

FILE: src/extended_gcd_mod_inverse.sv
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse
// extended euclid gcd, bezout coefficients and modular inverse
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid with i_value_a and i_modulus; o_in_stall high
//   while an item is in work, one item at a time
//   output channel: o_out_valid with gcd, coefficients, inverse and flag;
//   result registers hold steady while i_out_stall is high
//   each euclid iteration tests b for zero, runs the radix-2 divider and
//   the shift-add multiplier, then updates; once b is zero and no earlier
//   result is held, the result registers load and output valid rises
//   a result stalled at the output does not block the next item's work; the
//   next result waits until the previous one transfers
//   reset: synchronous, active low, clears the sequencer and output valid
// ----------------------------------------------------------------------------
`include "extended_gcd_mod_inverse_macros.svh"
module extended_gcd_mod_inverse
    import egm_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_value_a,
    input  logic [63:0] i_modulus,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_gcd_value,
    output logic [63:0] o_coeff_a,
    output logic [63:0] o_coeff_b,
    output logic [63:0] o_inverse,
    output logic        o_has_inverse
);
    t_egm_cmd w_cmd;
    t_egm_sts w_sts;

    egm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    egm_dpath #(.WORD_WIDTH(WORD_WIDTH)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_value_a     (i_value_a),
        .i_modulus     (i_modulus),
        .o_gcd_value   (o_gcd_value),
        .o_coeff_a     (o_coeff_a),
        .o_coeff_b     (o_coeff_b),
        .o_inverse     (o_inverse),
        .o_has_inverse (o_has_inverse)
    );

    `EGM_ASSERT_IMPL(a_flag_inv, i_clk, i_rst_n, o_out_valid && !o_has_inverse, o_inverse == 64'd0)
    `EGM_ASSERT_IMPL(a_flag_gcd, i_clk, i_rst_n, o_out_valid && o_has_inverse, o_gcd_value == 64'd1)
    `EGM_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, w_cmd.load, o_in_stall)
endmodule

FILE: src/egm_ctrl.sv
// ----------------------------------------------------------------------------
// egm_ctrl
// sequencer: load, divide, multiply-update loop, finish
// ----------------------------------------------------------------------------
module egm_ctrl
    import egm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_egm_sts i_sts,
    output t_egm_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.b_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_TEST;
            end
            S_FIN: begin
                if (!n_valid) begin
                    o_cmd.finish = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
endmodule

FILE: src/egm_dpath.sv
// ----------------------------------------------------------------------------
// egm_dpath
// operand registers, radix-2 divider, shift-add multiplier, result registers
// ----------------------------------------------------------------------------
module egm_dpath
    import egm_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_egm_cmd              i_cmd,
    output t_egm_sts              o_sts,
    input  logic [63:0]           i_value_a,
    input  logic [63:0]           i_modulus,
    output logic [63:0]           o_gcd_value,
    output logic [63:0]           o_coeff_a,
    output logic [63:0]           o_coeff_b,
    output logic [63:0]           o_inverse,
    output logic                  o_has_inverse
);
    localparam int CW = $clog2(WORD_WIDTH + 1);
    localparam int W  = WORD_WIDTH;

    logic [W-1:0] r_a, r_b, r_n, r_px, r_x, r_py, r_y;
    logic [W-1:0] r_q, r_rem, r_mq, r_px_mul, r_py_mul, r_mx, r_my;
    logic [W-1:0] r_md;
    logic         r_nn, r_qneg;
    logic [CW-1:0] r_cnt;

    logic [W-1:0] w_ma, w_mb, w_trial_hi, w_rem_fin, w_q_fin;
    logic [W:0]   w_sub;
    logic [W-1:0] w_shift;
    logic         w_ok;
    logic [W-1:0] w_inv;

    assign w_ma = r_a[W-1] ? (~r_a + 1'b1) : r_a;
    assign w_mb = r_b[W-1] ? (~r_b + 1'b1) : r_b;

    // restoring division: r_rem partial remainder, r_q holds dividend bits then quotient
    assign w_shift    = {r_rem[W-2:0], r_q[W-1]};
    assign w_sub      = {r_rem[W-1], w_shift} - {1'b0, r_md};
    assign w_trial_hi = w_sub[W-1:0];
    assign w_rem_fin  = r_nn ? (~r_rem + 1'b1) : r_rem;
    assign w_q_fin    = r_qneg ? (~r_q + 1'b1) : r_q;

    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.div_last = (r_cnt == CW'(1));
    assign o_sts.mul_last = (r_cnt == CW'(1));

    assign w_ok  = (r_a == W'(1));
    assign w_inv = r_px[W-1] ? (r_px + r_n) : r_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_a  <= i_value_a[W-1:0];
                r_b  <= i_modulus[W-1:0];
                r_n  <= i_modulus[W-1:0];
                r_px <= W'(1);
                r_x  <= '0;
                r_py <= '0;
                r_y  <= W'(1);
            end
            if (i_cmd.div_start) begin
                r_rem  <= '0;
                r_q    <= w_ma;
                r_md   <= w_mb;
                r_nn   <= r_a[W-1];
                r_qneg <= r_a[W-1] ^ r_b[W-1];
                r_cnt  <= CW'(W);
            end
            if (i_cmd.div_step) begin
                if (!w_sub[W] || r_rem[W-1]) begin
                    r_rem <= w_trial_hi;
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
                if (o_sts.div_last) begin
                    r_cnt    <= CW'(W);
                    r_px_mul <= r_x;
                    r_py_mul <= r_y;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            if (i_cmd.mul_step) begin
                // product of quotient and x, y; quotient shifted out from the top
                if (r_cnt == CW'(W)) begin
                    r_mq <= {w_q_fin[W-2:0], 1'b0};
                    r_mx <= w_q_fin[W-1] ? r_px_mul : '0;
                    r_my <= w_q_fin[W-1] ? r_py_mul : '0;
                end else begin
                    r_mx <= {r_mx[W-2:0], 1'b0} + (r_mq[W-1] ? r_px_mul : '0);
                    r_my <= {r_my[W-2:0], 1'b0} + (r_mq[W-1] ? r_py_mul : '0);
                    r_mq <= {r_mq[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.update) begin
                r_a  <= r_b;
                r_b  <= w_rem_fin;
                r_x  <= r_px - r_mx;
                r_px <= r_x;
                r_y  <= r_py - r_my;
                r_py <= r_y;
            end
            if (i_cmd.finish) begin
                o_gcd_value   <= {{(64-W){r_a[W-1]}}, r_a};
                o_coeff_a     <= {{(64-W){r_px[W-1]}}, r_px};
                o_coeff_b     <= {{(64-W){r_py[W-1]}}, r_py};
                o_inverse     <= w_ok ? {{(64-W){1'b0}}, w_inv} : '0;
                o_has_inverse <= w_ok;
            end
        end
    end
endmodule
